[src/pmlru_pkg.sv]
// Shared types and constants for the paged MMU with per-process LRU replacement.
// No dependencies.
`timescale 1ns / 1ps
package pmlru_pkg;

  localparam int unsigned PROCESSES = 16;
  localparam int unsigned PAGES     = 64;
  localparam int unsigned FRAMES    = 64;

  localparam int unsigned ProcW  = 4;
  localparam int unsigned PageW  = 6;
  localparam int unsigned FrameW = 6;
  localparam int unsigned EntW   = ProcW + PageW;
  localparam int unsigned CntW   = 7;
  localparam int unsigned StampW = 32;

  localparam logic [StampW-1:0] StampMax = '1;

  typedef enum logic [1:0] {
    ACT_ACCESS = 2'd0,
    ACT_TERM   = 2'd1,
    ACT_PUSH   = 2'd2,
    ACT_QUOTA  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_FAULT   = 3'd1,
    ST_INVALID = 3'd2,
    ST_TERM    = 3'd3,
    ST_SETUP   = 3'd4,
    ST_NOFRAME = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] process;
    logic [7:0] page;
    logic [5:0] frame;
    logic [6:0] quota;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  frame_out;
    logic [31:0] fault_count;
  } rsp_t;

endpackage

[src/paged_mmu_lru_replacement_core.sv]
// Top level of the paged MMU with per-process LRU replacement.
// Depends on pmlru_pkg and pmlru_ram.
// An eviction fault reads all PAGES entries of the process, one entry after another. A
// terminate or an invalid page releases the same way. One item at a time: the input stays
// not ready until the result has been transferred out.
// Reset (asynchronous, active low) clears control state and counters, then a pass over all
// PROCESSES*PAGES entries clears the page-table valid bits before the first input transfer.
`timescale 1ns / 1ps
module paged_mmu_lru_replacement_core
  import pmlru_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rsp_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_LOOK, S_LWAIT, S_DECIDE, S_SCAN, S_SWAIT, S_EVICT, S_REL,
    S_RPUSH, S_POP, S_PWAIT, S_FILL
  } state_e;

  state_e state_q;
  req_t   req_q;
  rsp_t   rsp_q;
  logic   out_valid_q;
  logic [6:0] ppp_q;
  logic [StampW-1:0] counter_q;
  logic [CntW-1:0] free_cnt_q;
  logic [CntW-1:0] quota_q [PROCESSES];
  logic [CntW-1:0] used_q  [PROCESSES];
  logic [31:0]     faults_q[PROCESSES];
  logic [EntW-1:0] clr_q;

  // Scan bookkeeping
  logic [PageW:0]      idx_q;
  logic [PageW-1:0]    prev_q;
  logic                found_q;
  logic [PageW-1:0]    best_q;
  logic [StampW-1:0]   bstamp_q;
  logic                release_inv_q;
  logic [FrameW-1:0]   nf_q;

  // Page-table memory: valid bit, frame and stamp together
  logic                       pt_we;
  logic [EntW-1:0]            pt_addr;
  logic [FrameW+StampW:0]     pt_wdata, pt_rdata;
  // Free stack memory
  logic              fs_we;
  logic [FrameW-1:0] fs_addr;
  logic [FrameW-1:0] fs_wdata, fs_rdata;

  pmlru_ram #(.Width(FrameW + StampW + 1), .Depth(PROCESSES * PAGES)) u_pt (
    .clk_i, .we_i(pt_we), .addr_i(pt_addr), .wdata_i(pt_wdata), .rdata_o(pt_rdata)
  );
  pmlru_ram #(.Width(FrameW), .Depth(FRAMES)) u_fs (
    .clk_i, .we_i(fs_we), .addr_i(fs_addr), .wdata_i(fs_wdata), .rdata_o(fs_rdata)
  );

  logic [ProcW-1:0] proc;
  logic [PageW-1:0] pg;
  logic [EntW-1:0]  ent;
  logic [EntW-1:0]  idx_ent;
  logic             rd_valid;
  logic [FrameW-1:0] rd_frame;
  logic [StampW-1:0] rd_stamp;
  logic             page_ok;

  assign proc     = req_q.process;
  assign pg       = req_q.page[PageW-1:0];
  assign ent      = {proc, pg};
  assign idx_ent  = {proc, idx_q[PageW-1:0]};
  assign rd_valid = pt_rdata[FrameW+StampW];
  assign rd_frame = pt_rdata[FrameW+StampW-1:StampW];
  assign rd_stamp = pt_rdata[StampW-1:0];
  assign page_ok  = ({1'b0, req_q.page} < {2'b0, ppp_q}) &&
                    ({1'b0, req_q.page} < 9'(PAGES));

  always_comb begin
    pt_we    = 1'b0;
    pt_addr  = ent;
    pt_wdata = {1'b1, nf_q, counter_q};
    fs_we    = 1'b0;
    fs_addr  = free_cnt_q[FrameW-1:0];
    fs_wdata = req_q.frame;
    unique case (state_q)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_addr  = clr_q;
        pt_wdata = '0;
      end
      S_LOOK: pt_addr = ent;
      S_DECIDE: begin
        if (rd_valid) begin
          pt_we    = 1'b1;
          pt_wdata = {1'b1, rd_frame, counter_q};
        end
      end
      S_SCAN, S_REL: pt_addr = idx_ent;
      S_EVICT: begin
        if (found_q) begin
          pt_we    = 1'b1;
          pt_addr  = {proc, best_q};
          pt_wdata = '0;
        end
      end
      S_RPUSH: begin
        pt_addr  = {proc, prev_q};
        pt_we    = rd_valid;
        pt_wdata = '0;
        fs_we    = rd_valid && free_cnt_q < CntW'(FRAMES);
        fs_wdata = rd_frame;
      end
      // The count was already decremented, so it now addresses the top of the stack.
      S_POP: fs_addr = free_cnt_q[FrameW-1:0];
      S_FILL: pt_we = 1'b1;
      S_IDLE: begin
        fs_we = in_valid_i && !out_valid_q && in_data_i.action == ACT_PUSH &&
                free_cnt_q < CntW'(FRAMES);
        fs_wdata = in_data_i.frame;
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  logic [31:0] cur_faults;
  assign cur_faults = faults_q[proc];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      out_valid_q   <= 1'b0;
      ppp_q         <= 7'd64;
      counter_q     <= '0;
      free_cnt_q    <= '0;
      clr_q         <= '0;
      idx_q         <= '0;
      found_q       <= 1'b0;
      release_inv_q <= 1'b0;
      for (int i = 0; i < PROCESSES; i++) begin
        quota_q[i]  <= '0;
        used_q[i]   <= '0;
        faults_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) ppp_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            req_q <= in_data_i;
            if (in_data_i.action == ACT_PUSH) begin
              if (free_cnt_q < CntW'(FRAMES)) free_cnt_q <= free_cnt_q + 1'b1;
              rsp_q       <= '{status: ST_SETUP, frame_out: '0,
                               fault_count: faults_q[in_data_i.process]};
              out_valid_q <= 1'b1;
            end else if (in_data_i.action == ACT_QUOTA) begin
              quota_q[in_data_i.process] <= in_data_i.quota;
              rsp_q       <= '{status: ST_SETUP, frame_out: '0,
                               fault_count: faults_q[in_data_i.process]};
              out_valid_q <= 1'b1;
            end else if (in_data_i.action == ACT_TERM) begin
              idx_q         <= '0;
              release_inv_q <= 1'b0;
              state_q       <= S_REL;
            end else begin
              if (counter_q != StampMax) counter_q <= counter_q + 1'b1;
              state_q <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (!page_ok) begin
            idx_q         <= '0;
            release_inv_q <= 1'b1;
            state_q       <= S_REL;
          end else begin
            state_q <= S_LWAIT;
          end
        end
        S_LWAIT: state_q <= S_DECIDE;
        S_DECIDE: begin
          if (rd_valid) begin
            rsp_q       <= '{status: ST_HIT, frame_out: rd_frame, fault_count: cur_faults};
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            if (cur_faults != 32'hFFFF_FFFF) faults_q[proc] <= cur_faults + 1'b1;
            if (free_cnt_q != '0 && used_q[proc] < quota_q[proc]) begin
              free_cnt_q     <= free_cnt_q - 1'b1;
              used_q[proc]   <= used_q[proc] + 1'b1;
              state_q        <= S_POP;
            end else begin
              idx_q   <= '0;
              found_q <= 1'b0;
              state_q <= S_SCAN;
            end
          end
        end
        S_POP: state_q <= S_PWAIT;
        S_PWAIT: begin
          nf_q    <= fs_rdata;
          state_q <= S_FILL;
        end
        S_SCAN: begin
          // Issue read for entry idx_q, then compare it in S_SWAIT.
          prev_q  <= idx_q[PageW-1:0];
          idx_q   <= idx_q + 1'b1;
          state_q <= S_SWAIT;
        end
        S_SWAIT: begin
          if (rd_valid && (!found_q || rd_stamp < bstamp_q)) begin
            found_q  <= 1'b1;
            best_q   <= prev_q;
            bstamp_q <= rd_stamp;
            nf_q     <= rd_frame;
          end
          state_q <= (idx_q == (PageW+1)'(PAGES)) ? S_EVICT : S_SCAN;
        end
        S_EVICT: begin
          if (found_q) begin
            state_q <= S_FILL;
          end else begin
            rsp_q       <= '{status: ST_NOFRAME, frame_out: '0, fault_count: faults_q[proc]};
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_FILL: begin
          rsp_q        <= '{status: ST_FAULT, frame_out: nf_q, fault_count: faults_q[proc]};
          out_valid_q  <= 1'b1;
          state_q      <= S_IDLE;
        end
        S_REL: begin
          prev_q  <= idx_q[PageW-1:0];
          idx_q   <= idx_q + 1'b1;
          state_q <= S_RPUSH;
        end
        S_RPUSH: begin
          if (rd_valid && free_cnt_q < CntW'(FRAMES)) free_cnt_q <= free_cnt_q + 1'b1;
          if (idx_q == (PageW+1)'(PAGES)) begin
            used_q[proc] <= '0;
            rsp_q        <= '{status: release_inv_q ? ST_INVALID : ST_TERM,
                              frame_out: '0, fault_count: faults_q[proc]};
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            state_q <= S_REL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[src/pmlru_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pmlru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[src/pmlru_checker.sv]
// Port-level checker for the paged MMU core, bound to the top level.
// Depends on pmlru_pkg.
`timescale 1ns / 1ps
module pmlru_checker
  import pmlru_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);

  // A transfer in is not taken while a result still waits.
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_NOFRAME) else $error("bad status");

  a_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !(out_data_o.status == ST_HIT || out_data_o.status == ST_FAULT)
    |-> out_data_o.frame_out == '0) else $error("frame on non-mapping result");

endmodule

bind paged_mmu_lru_replacement_core pmlru_checker u_pmlru_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

[bench/tb_paged_mmu_lru_replacement_core.sv]
// Self-checking testbench for the paged MMU with per-process LRU replacement.
// Depends on pmlru_pkg and paged_mmu_lru_replacement_core; a built-in predictor
// tracks page tables, the free-frame stack and per-process counters.
`timescale 1ns / 1ps
module tb_paged_mmu_lru_replacement_core;
  import pmlru_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;
  logic cfg_we_i;
  logic [6:0] cfg_wdata_i;

  paged_mmu_lru_replacement_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  localparam int unsigned CycleLimit = 1500000;

  // Predictor state.
  logic [6:0]        page_limit;
  logic              map_valid [PROCESSES*PAGES];
  logic [5:0]        map_frame [PROCESSES*PAGES];
  logic [31:0]       map_stamp [PROCESSES*PAGES];
  logic [5:0]        free_frames [FRAMES];
  int unsigned       free_depth;
  logic [31:0]       use_clock;
  logic [6:0]        quota_of [PROCESSES];
  logic [6:0]        held_of [PROCESSES];
  logic [31:0]       faults_of [PROCESSES];

  rsp_t        expected_rsps[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;
  bit          failed;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void push_free(logic [5:0] f);
    if (free_depth < FRAMES) begin
      free_frames[free_depth] = f;
      free_depth++;
    end
  endfunction

  function automatic void release_frames(int unsigned p);
    for (int unsigned k = 0; k < PAGES; k++) begin
      if (map_valid[p*PAGES+k]) begin
        push_free(map_frame[p*PAGES+k]);
        map_valid[p*PAGES+k] = 1'b0;
      end
    end
    held_of[p] = '0;
  endfunction

  function automatic rsp_t translate(req_t r);
    rsp_t        o;
    int unsigned p;
    int unsigned e;
    int unsigned best;
    logic [31:0] bstamp;
    bit          found;
    bit          got;
    logic [5:0]  nf;
    p = r.process;
    o.status = ST_INVALID;
    o.frame_out = '0;
    o.fault_count = '0;
    found = 0;
    got = 0;
    nf = '0;
    best = 0;
    bstamp = '0;
    if (r.action == ACT_PUSH) begin
      push_free(r.frame);
      o.status = ST_SETUP;
      o.fault_count = faults_of[p];
    end else if (r.action == ACT_QUOTA) begin
      quota_of[p] = r.quota;
      o.status = ST_SETUP;
      o.fault_count = faults_of[p];
    end else if (r.action == ACT_TERM) begin
      release_frames(p);
      o.status = ST_TERM;
      o.fault_count = faults_of[p];
    end else begin
      if (use_clock != StampMax) use_clock++;
      if (r.page >= page_limit || r.page >= PAGES) begin
        release_frames(p);
        o.status = ST_INVALID;
      end else begin
        e = p*PAGES + r.page;
        if (map_valid[e]) begin
          o.frame_out = map_frame[e];
          map_stamp[e] = use_clock;
          o.status = ST_HIT;
        end else begin
          if (faults_of[p] != StampMax) faults_of[p]++;
          if (free_depth > 0 && held_of[p] < quota_of[p]) begin
            free_depth--;
            nf = free_frames[free_depth];
            held_of[p]++;
            got = 1;
          end else begin
            for (int unsigned k = 0; k < PAGES; k++) begin
              if (map_valid[p*PAGES+k] && (!found || map_stamp[p*PAGES+k] < bstamp)) begin
                found = 1;
                best = k;
                bstamp = map_stamp[p*PAGES+k];
              end
            end
            if (found) begin
              nf = map_frame[p*PAGES+best];
              map_valid[p*PAGES+best] = 1'b0;
              got = 1;
            end
          end
          if (got) begin
            map_valid[e] = 1'b1;
            map_frame[e] = nf;
            map_stamp[e] = use_clock;
            o.frame_out = nf;
            o.status = ST_FAULT;
          end else begin
            o.status = ST_NOFRAME;
          end
        end
      end
      o.fault_count = faults_of[p];
    end
    return o;
  endfunction

  // Sends one item, holding it until the transfer; idle gaps drawn with send_idle_pct may come first.
  task automatic send_req(action_e a, int unsigned p, int unsigned pg,
                          int unsigned f, int unsigned q);
    req_t r;
    r.action = a;
    r.process = p[3:0];
    r.page = pg[7:0];
    r.frame = f[5:0];
    r.quota = q[6:0];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    expected_rsps.push_back(translate(r));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (PAGES + 20) @(posedge clk_i);
  endtask

  task automatic set_page_limit(int unsigned v);
    go_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[6:0];
    page_limit = v[6:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random page biased towards the configured range, sometimes beyond it.
  function automatic int unsigned pick_page();
    if ($urandom_range(19) == 0) return $urandom_range(255);
    if (page_limit == 0) return 0;
    return $urandom_range(page_limit - 1);
  endfunction

  task automatic test_directed();
    set_page_limit(64);
    send_req(ACT_ACCESS, 0, 0, 0, 0);          // nothing to evict
    send_req(ACT_QUOTA, 0, 0, 0, 2);
    send_req(ACT_PUSH, 0, 0, 63, 0);
    send_req(ACT_PUSH, 15, 0, 0, 0);
    send_req(ACT_PUSH, 3, 0, 42, 0);
    send_req(ACT_ACCESS, 0, 0, 0, 0);
    send_req(ACT_ACCESS, 0, 63, 0, 0);
    send_req(ACT_ACCESS, 0, 0, 0, 0);          // hit
    send_req(ACT_ACCESS, 0, 5, 0, 0);          // quota reached: LRU eviction
    send_req(ACT_ACCESS, 0, 64, 0, 0);         // invalid page releases
    send_req(ACT_ACCESS, 0, 255, 0, 0);
    send_req(ACT_QUOTA, 15, 0, 0, 64);
    send_req(ACT_QUOTA, 7, 0, 0, 127);
    send_req(ACT_ACCESS, 15, 10, 0, 0);
    send_req(ACT_TERM, 15, 0, 0, 0);
    send_req(ACT_TERM, 4, 0, 0, 0);
    for (int i = 0; i < 66; i++) send_req(ACT_PUSH, 1, 0, i % 64, 0);  // full stack
    set_page_limit(1);
    send_req(ACT_ACCESS, 2, 0, 0, 0);
    send_req(ACT_ACCESS, 2, 1, 0, 0);
    set_page_limit(0);
    send_req(ACT_ACCESS, 2, 0, 0, 0);
  endtask

  task automatic test_random(int unsigned n, int unsigned limit);
    int unsigned p;
    set_page_limit(limit);
    for (int unsigned i = 0; i < n; i++) begin
      p = $urandom_range(15);
      case ($urandom_range(19))
        0:       send_req(ACT_TERM, p, $urandom_range(255), $urandom_range(63), 0);
        1, 2:    send_req(ACT_PUSH, p, $urandom_range(255), $urandom_range(63),
                          $urandom_range(127));
        3:       send_req(ACT_QUOTA, p, $urandom_range(255), 0,
                          $urandom_range(3) == 0 ? $urandom_range(127) : $urandom_range(8));
        default: send_req(ACT_ACCESS, p, pick_page(), $urandom_range(63),
                          $urandom_range(127));
      endcase
      if (i == n / 2) go_idle();
    end
  endtask

  // Checks each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_o);
          failed = 1;
        end else begin
          want = expected_rsps.pop_front();
          if (out_data_o.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_data_o.status);
          if (out_data_o.frame_out !== want.frame_out)
            $display("%0t: frame_out expected %0d actual %0d", $time, want.frame_out,
                     out_data_o.frame_out);
          if (out_data_o.fault_count !== want.fault_count)
            $display("%0t: fault_count expected %0d actual %0d", $time,
                     want.fault_count, out_data_o.fault_count);
          if (out_data_o !== want) failed = 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    page_limit = 64;
    for (int i = 0; i < PROCESSES*PAGES; i++) begin
      map_valid[i] = 1'b0;
      map_frame[i] = '0;
      map_stamp[i] = '0;
    end
    for (int i = 0; i < FRAMES; i++) free_frames[i] = '0;
    for (int i = 0; i < PROCESSES; i++) begin
      quota_of[i] = '0;
      held_of[i] = '0;
      faults_of[i] = '0;
    end
    free_depth = 0;
    use_clock = '0;
    failed = 0;
    cycle_count = 0;
    send_idle_pct = 33;
    recv_idle_pct = 45;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(500, 64);
    send_idle_pct = 45;
    recv_idle_pct = 33;
    test_random(400, 9);
    test_random(100, 127);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(600, 20);
    go_idle();

    if (!failed && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
